### rtl/mlbd_pkg.sv
`default_nettype none

package mlbd_pkg;

    // Number of logical channels and width of the phase timers.
    localparam int CHANNELS  = 4;
    localparam int TIME_BITS = 16;

    // Width of a stored channel index.
    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Fixed widths of the command fields.
    localparam int CMD_W   = 3;
    localparam int SEL_W   = 2;
    localparam int COUNT_W = 2;
    localparam int LED_W   = 6;
    localparam int TICKS_W = 16;

    typedef logic [TIME_BITS-1:0] time_t;
    typedef logic [LED_W-1:0]     led_t;
    typedef logic [CH_W-1:0]      chan_t;

    // Command codes.
    typedef enum logic [CMD_W-1:0] {
        CMD_SET_COUNT = 3'd0,
        CMD_SET_BITS  = 3'd1,
        CMD_SELECT    = 3'd2,
        CMD_START     = 3'd3,
        CMD_STOP      = 3'd4,
        CMD_TICK      = 3'd5
    } cmd_t;

    // One command as it travels from the input register to the engine.
    typedef struct packed {
        logic [CMD_W-1:0]   cmd;
        logic [SEL_W-1:0]   channel_sel;
        logic [COUNT_W-1:0] low_count;
        logic [COUNT_W-1:0] high_count;
        logic [LED_W-1:0]   led_bits;
        logic [TICKS_W-1:0] on_ticks;
        logic [TICKS_W-1:0] off_ticks;
    } item_t;

    // Thermometer code for a bar of three LEDs.
    function automatic logic [2:0] thermo3(input logic [COUNT_W-1:0] n);
        logic [2:0] t;
        unique case (n)
            2'd0:    t = 3'b000;
            2'd1:    t = 3'b001;
            2'd2:    t = 3'b011;
            default: t = 3'b111;
        endcase
        return t;
    endfunction

    // Fit a tick count from the command into the timer width.
    function automatic time_t to_time(input logic [TICKS_W-1:0] ticks);
        logic [31:0] wide;
        wide = {16'd0, ticks};
        return wide[TIME_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/multichannel_led_blink_display_core.sv
// Six-LED blink display with several logical channels.
// Input channel: in_valid / in_stall with one command per transfer (cmd,
// channel_sel, low_count, high_count, led_bits, on_ticks, off_ticks).
// Commands set a pattern, select the shown channel, start or stop blinking,
// or deliver one time tick.
// Output channel: out_valid / out_stall; every command yields exactly one
// transfer carrying led_drive, the LED levels after that command.
// Path: a command is held in the input register and its result in the output
// register, two register stages in all.
// Throughput: one command per cycle unless the receiver stalls; the state
// update is short combinational logic between the input and output registers.
// Reset (rst_n low, asynchronous) clears all patterns, blink flags, phase
// timers and both pipeline valid flags; the display state starts all dark.
// When the receiver stalls, the result stays in the output register, one
// more command waits in the input register, and in_stall then rises until
// the output is taken.
`default_nettype none

module multichannel_led_blink_display_core (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [2:0]  cmd,
    input  wire logic [1:0]  channel_sel,
    input  wire logic [1:0]  low_count,
    input  wire logic [1:0]  high_count,
    input  wire logic [5:0]  led_bits,
    input  wire logic [15:0] on_ticks,
    input  wire logic [15:0] off_ticks,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [5:0]       led_drive
);

    mlbd_pkg::item_t item_in;
    mlbd_pkg::item_t item_stage;
    logic            stage_valid;
    logic            can_load;
    logic            advance;
    mlbd_pkg::led_t  drive_next;

    // Gather the command fields.
    assign item_in = '{cmd: cmd, channel_sel: channel_sel, low_count: low_count,
                       high_count: high_count, led_bits: led_bits,
                       on_ticks: on_ticks, off_ticks: off_ticks};

    // A held command moves on when the output register has room.
    assign advance = stage_valid && can_load;

    mlbd_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .item_in     (item_in),
        .advance     (advance),
        .stage_valid (stage_valid),
        .item_out    (item_stage)
    );

    mlbd_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (advance),
        .item      (item_stage),
        .drive_out (drive_next)
    );

    mlbd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance),
        .drive_in  (drive_next),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .led_drive (led_drive),
        .can_load  (can_load)
    );

    // Input back-pressure only comes from a stalled, full output.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall && stage_valid))
        else $error("input stalled without a full output");

    // A command that moves on always leaves a result behind it.
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid)
        else $error("command moved on without a result");

    // The output register never drops a result that the receiver stalls.
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result lost");

endmodule

`default_nettype wire

### rtl/mlbd_in_reg.sv
`default_nettype none

module mlbd_in_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire mlbd_pkg::item_t item_in,
    input  wire logic           advance,
    output logic                stage_valid,
    output mlbd_pkg::item_t     item_out
);

    logic            valid_reg;
    logic            valid_next;
    mlbd_pkg::item_t item_reg;
    logic            take;

    // The register can take a new command when it is empty or moving on.
    assign in_stall = valid_reg && !advance;
    assign take     = in_valid && !in_stall;

    // Occupancy of the input register.
    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload capture on each accepted transfer.
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_in;
    end

    assign stage_valid = valid_reg;
    assign item_out    = item_reg;

endmodule

`default_nettype wire

### rtl/mlbd_engine.sv
`default_nettype none

module mlbd_engine (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            fire,
    input  wire mlbd_pkg::item_t item,
    output mlbd_pkg::led_t       drive_out
);

    localparam logic [4:0] CHAN_LIMIT = 5'(mlbd_pkg::CHANNELS);

    mlbd_pkg::led_t  pattern_reg [mlbd_pkg::CHANNELS];
    mlbd_pkg::led_t  pattern_next [mlbd_pkg::CHANNELS];
    logic            blink_reg [mlbd_pkg::CHANNELS];
    logic            blink_next [mlbd_pkg::CHANNELS];
    mlbd_pkg::time_t on_reg [mlbd_pkg::CHANNELS];
    mlbd_pkg::time_t on_next [mlbd_pkg::CHANNELS];
    mlbd_pkg::time_t off_reg [mlbd_pkg::CHANNELS];
    mlbd_pkg::time_t off_next [mlbd_pkg::CHANNELS];
    mlbd_pkg::chan_t shown_reg;
    mlbd_pkg::chan_t shown_next;
    logic            phase_on_reg;
    logic            phase_on_next;
    mlbd_pkg::time_t remain_reg;
    mlbd_pkg::time_t remain_next;
    mlbd_pkg::led_t  drive_reg;
    mlbd_pkg::led_t  drive_next;

    logic [4:0]      sel_ext;
    logic            ch_ok;
    mlbd_pkg::chan_t ch;
    mlbd_pkg::led_t  new_pattern;
    logic            is_shown;

    // Decode the addressed channel.
    assign sel_ext  = {3'd0, item.channel_sel};
    assign ch_ok    = sel_ext < CHAN_LIMIT;
    assign ch       = sel_ext[mlbd_pkg::CH_W-1:0];
    assign is_shown = ch == shown_reg;

    // Pattern carried by the two set commands.
    always_comb
    begin
        if (item.cmd == mlbd_pkg::CMD_SET_COUNT)
            new_pattern = {mlbd_pkg::thermo3(item.high_count),
                           mlbd_pkg::thermo3(item.low_count)};
        else
            new_pattern = item.led_bits;
    end

    // State update for one command.
    always_comb
    begin
        pattern_next  = pattern_reg;
        blink_next    = blink_reg;
        on_next       = on_reg;
        off_next      = off_reg;
        shown_next    = shown_reg;
        phase_on_next = phase_on_reg;
        remain_next   = remain_reg;
        drive_next    = drive_reg;
        unique case (item.cmd)
            mlbd_pkg::CMD_SET_COUNT, mlbd_pkg::CMD_SET_BITS:
            begin
                if (ch_ok)
                begin
                    pattern_next[ch] = new_pattern;
                    if (is_shown && !blink_reg[ch])
                        drive_next = new_pattern;
                end
            end
            mlbd_pkg::CMD_SELECT:
            begin
                if (ch_ok && !is_shown)
                begin
                    shown_next = ch;
                    if (blink_reg[ch])
                    begin
                        drive_next    = '0;
                        phase_on_next = 1'b0;
                        remain_next   = off_reg[ch];
                    end
                    else
                    begin
                        drive_next = pattern_reg[ch];
                    end
                end
            end
            mlbd_pkg::CMD_START:
            begin
                if (ch_ok)
                begin
                    blink_next[ch] = 1'b1;
                    on_next[ch]    = mlbd_pkg::to_time(item.on_ticks);
                    off_next[ch]   = mlbd_pkg::to_time(item.off_ticks);
                    if (is_shown && !blink_reg[ch])
                    begin
                        drive_next    = '0;
                        phase_on_next = 1'b0;
                        remain_next   = mlbd_pkg::to_time(item.off_ticks);
                    end
                end
            end
            mlbd_pkg::CMD_STOP:
            begin
                if (ch_ok)
                begin
                    blink_next[ch] = 1'b0;
                    if (is_shown)
                        drive_next = pattern_reg[ch];
                end
            end
            mlbd_pkg::CMD_TICK:
            begin
                if (blink_reg[shown_reg])
                begin
                    if (remain_reg > mlbd_pkg::time_t'(1))
                    begin
                        remain_next = remain_reg - mlbd_pkg::time_t'(1);
                    end
                    else if (phase_on_reg)
                    begin
                        drive_next    = '0;
                        phase_on_next = 1'b0;
                        remain_next   = off_reg[shown_reg];
                    end
                    else
                    begin
                        drive_next    = pattern_reg[shown_reg];
                        phase_on_next = 1'b1;
                        remain_next   = on_reg[shown_reg];
                    end
                end
            end
            default:
            begin
                drive_next = drive_reg;
            end
        endcase
    end

    // State registers, written once per command.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < mlbd_pkg::CHANNELS; i++)
            begin
                pattern_reg[i] <= '0;
                blink_reg[i]   <= 1'b0;
                on_reg[i]      <= '0;
                off_reg[i]     <= '0;
            end
            shown_reg    <= '0;
            phase_on_reg <= 1'b0;
            remain_reg   <= '0;
            drive_reg    <= '0;
        end
        else if (fire)
        begin
            pattern_reg  <= pattern_next;
            blink_reg    <= blink_next;
            on_reg       <= on_next;
            off_reg      <= off_next;
            shown_reg    <= shown_next;
            phase_on_reg <= phase_on_next;
            remain_reg   <= remain_next;
            drive_reg    <= drive_next;
        end
    end

    assign drive_out = drive_next;

    // A shown channel that does not blink always drives its own pattern.
    a_steady_drive: assert property (@(posedge clk) disable iff (!rst_n)
        !blink_reg[shown_reg] |-> drive_reg == pattern_reg[shown_reg])
        else $error("steady channel does not drive its pattern");

    // During an off phase of a blinking channel all LEDs are dark.
    a_off_dark: assert property (@(posedge clk) disable iff (!rst_n)
        (blink_reg[shown_reg] && !phase_on_reg) |-> drive_reg == '0)
        else $error("LEDs lit during off phase");

    // A tick moves the timer only while the shown channel blinks.
    a_timer_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && item.cmd == mlbd_pkg::CMD_TICK && !blink_reg[shown_reg])
        |=> $stable(remain_reg) && $stable(phase_on_reg))
        else $error("phase timer moved without blinking");

endmodule

`default_nettype wire

### rtl/mlbd_out_reg.sv
`default_nettype none

module mlbd_out_reg (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           load,
    input  wire mlbd_pkg::led_t drive_in,
    input  wire logic           out_stall,
    output logic                out_valid,
    output mlbd_pkg::led_t      led_drive,
    output logic                can_load
);

    logic           valid_reg;
    logic           valid_next;
    mlbd_pkg::led_t led_reg;

    // Free when empty or when the held result leaves this cycle.
    assign can_load = !valid_reg || !out_stall;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (valid_reg && !out_stall)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Result data held until the receiver takes it.
    always_ff @(posedge clk)
    begin
        if (load)
            led_reg <= drive_in;
    end

    assign out_valid = valid_reg;
    assign led_drive = led_reg;

endmodule

`default_nettype wire
